/* hw/rtl/bg_window_tile_row_fetch_assert.svh */
// Assertion macros for the background tile row fetch block.
// Expects clk and synchronous active-low rst_n in the enclosing module.
`ifndef BG_WINDOW_TILE_ROW_FETCH_ASSERT_SVH
`define BG_WINDOW_TILE_ROW_FETCH_ASSERT_SVH

// clocked property, off while in reset
`define BGWF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must never hold out of reset
`define BGWF_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

/* hw/rtl/bgwf_pkg.sv */
// Shared types and constants for the background tile row fetch block.
// No dependencies.
`default_nettype none

package bgwf_pkg;

  localparam int unsigned BANK_AW           = 13;
  localparam int unsigned VRAM_AW           = BANK_AW + 1;
  localparam int unsigned TILES_PER_MAP_ROW = 32;
  localparam int unsigned TILE_BYTES        = 16;

  localparam logic [BANK_AW-1:0] MAP0_BASE     = 13'h1800;
  localparam logic [BANK_AW-1:0] MAP1_BASE     = 13'h1C00;
  localparam logic [BANK_AW-1:0] DATA_U_BASE   = 13'h0000;
  localparam logic [BANK_AW-1:0] DATA_S_BASE   = 13'h0800;
  localparam logic [7:0]         SIGNED_BIAS   = 8'h80;

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_FETCH = 1'b1;

  localparam logic [0:0] CFG_COLOR_MODE    = 1'b0;
  localparam logic [0:0] CFG_UNSIGNED_DATA = 1'b1;

  typedef struct packed {
    logic               en;
    logic               we;
    logic [VRAM_AW-1:0] addr;
    logic [7:0]         wdata;
  } vram_req_t;

endpackage

`default_nettype wire

/* hw/rtl/bg_window_tile_row_fetch.sv */
// Background/window tile row fetch, 2 bits per pixel: top level.
// Holds the config registers; instantiates bgwf_seq and bgwf_vram.
// Depends on bgwf_pkg.
//
// Input channel (in_valid/in_ready): a beat with in_mode = 0 writes one byte
// of video memory (bank in_write_bank, offset in_write_addr) and gives no
// result; a beat with in_mode = 1 fetches the tile row at in_pixel_x,
// in_pixel_y from the map chosen by in_map_select.
// Output channel (out_valid/out_ready): one beat per fetch, eight 2-bit
// colors in out_pixel_row (leftmost in bits 1:0) and the attribute byte.
// A write completes at the accepting edge. A fetch holds in_ready low
// through attribute (color mode only), plane 0, plane 1 and fin, where the
// result is loaded. The single-port video memory sets this order: one access
// per cycle for map, attribute and two plane bytes, via one address adder.
// A finished result sits in an output register, so the next beat is taken
// while it waits; a fetch that completes while that register is still full
// waits in its last step until the receiver takes the pending beat.
// Reset clears the handshake state, sets color mode off and unsigned tile
// data on; video memory contents are undefined until written.
// cfg_we writes cfg_wdata to register cfg_index (0 color mode, 1 unsigned
// tile data); the user must write only while the block is idle, unenforced.
`default_nettype none

module bg_window_tile_row_fetch (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [0:0]  cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_mode,
  input  wire logic        in_write_bank,
  input  wire logic [12:0] in_write_addr,
  input  wire logic [7:0]  in_write_data,
  input  wire logic [7:0]  in_pixel_x,
  input  wire logic [7:0]  in_pixel_y,
  input  wire logic        in_map_select,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      out_pixel_row,
  output logic [7:0]       out_attribute
);

  logic                color_mode_r;
  logic                unsigned_tile_data_r;
  bgwf_pkg::vram_req_t mem_req;
  logic [7:0]          mem_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_mode_r         <= 1'b0;
      unsigned_tile_data_r <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bgwf_pkg::CFG_COLOR_MODE:    color_mode_r         <= cfg_wdata[0];
        bgwf_pkg::CFG_UNSIGNED_DATA: unsigned_tile_data_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  bgwf_seq u_seq (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_mode            (in_mode),
    .in_write_bank      (in_write_bank),
    .in_write_addr      (in_write_addr),
    .in_write_data      (in_write_data),
    .in_pixel_x         (in_pixel_x),
    .in_pixel_y         (in_pixel_y),
    .in_map_select      (in_map_select),
    .color_mode         (color_mode_r),
    .unsigned_tile_data (unsigned_tile_data_r),
    .mem_req            (mem_req),
    .mem_rdata          (mem_rdata),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_pixel_row      (out_pixel_row),
    .out_attribute      (out_attribute)
  );

  bgwf_vram u_vram (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

endmodule

`default_nettype wire

/* hw/rtl/bgwf_vram.sv */
// Two-bank video memory, one access per cycle, registered read data.
// Depends on bgwf_pkg.
`default_nettype none

module bgwf_vram (
  input  wire logic              clk,
  input  wire bgwf_pkg::vram_req_t req,
  output logic [7:0]             rdata
);

  logic [7:0] mem_array [2**bgwf_pkg::VRAM_AW];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.en) begin
      if (req.we) begin
        mem_array[req.addr] <= req.wdata;
      end else begin
        rdata_r <= mem_array[req.addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

/* hw/rtl/bgwf_seq.sv */
// Fetch sequencer: shared address adder, memory access order, pixel decode
// and output register. Depends on bgwf_pkg and the assertion macro header.
`default_nettype none
`include "bg_window_tile_row_fetch_assert.svh"

module bgwf_seq (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 in_mode,
  input  wire logic                 in_write_bank,
  input  wire logic [12:0]          in_write_addr,
  input  wire logic [7:0]           in_write_data,
  input  wire logic [7:0]           in_pixel_x,
  input  wire logic [7:0]           in_pixel_y,
  input  wire logic                 in_map_select,
  input  wire logic                 color_mode,
  input  wire logic                 unsigned_tile_data,
  output bgwf_pkg::vram_req_t       mem_req,
  input  wire logic [7:0]           mem_rdata,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [15:0]               out_pixel_row,
  output logic [7:0]                out_attribute
);

  typedef enum logic [2:0] {S_IDLE, S_ATTR, S_PL0, S_PL1, S_FIN} state_t;

  state_t                          state_r;
  logic [bgwf_pkg::BANK_AW-1:0]    map_addr_r;
  logic [2:0]                      y_lo_r;
  logic [7:0]                      tile_r;
  logic [7:0]                      attr_r;
  logic [7:0]                      plane0_r;
  logic                            out_valid_r;
  logic [15:0]                     out_pixel_row_r;
  logic [7:0]                      out_attribute_r;

  logic [7:0]                      tile_sel;
  logic [7:0]                      attr_sel;
  logic [7:0]                      tile_idx;
  logic [2:0]                      row;
  logic                            plane_bit;
  logic [bgwf_pkg::BANK_AW-1:0]    add_a;
  logic [bgwf_pkg::BANK_AW-1:0]    add_b;
  logic [bgwf_pkg::BANK_AW-1:0]    sum;
  logic [15:0]                     row_dec;
  logic [2:0]                      sh;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    tile_sel = tile_r;
    attr_sel = attr_r;
    if (state_r == S_PL0) begin
      tile_sel = color_mode ? tile_r : mem_rdata;
      attr_sel = color_mode ? mem_rdata : 8'h00;
    end
    tile_idx  = unsigned_tile_data ? tile_sel : (tile_sel ^ bgwf_pkg::SIGNED_BIAS);
    row       = y_lo_r ^ {3{attr_sel[6]}};
    plane_bit = (state_r == S_PL1);
  end

  // shared address adder: map lookup in idle, tile data otherwise
  always_comb begin
    if (state_r == S_IDLE) begin
      add_a = in_map_select ? bgwf_pkg::MAP1_BASE : bgwf_pkg::MAP0_BASE;
      add_b = {3'b000, in_pixel_y[7:3], in_pixel_x[7:3]};
    end else begin
      add_a = unsigned_tile_data ? bgwf_pkg::DATA_U_BASE : bgwf_pkg::DATA_S_BASE;
      add_b = {1'b0, tile_idx, row, plane_bit};
    end
    sum = add_a + add_b;
  end

  always_comb begin
    mem_req = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          mem_req.en = 1'b1;
          if (in_mode == bgwf_pkg::MODE_FETCH) begin
            mem_req.addr = {1'b0, sum};
          end else begin
            mem_req.we    = 1'b1;
            mem_req.addr  = {in_write_bank, in_write_addr};
            mem_req.wdata = in_write_data;
          end
        end
      end
      S_ATTR: begin
        mem_req.en   = 1'b1;
        mem_req.addr = {1'b1, map_addr_r};
      end
      S_PL0, S_PL1: begin
        mem_req.en   = 1'b1;
        mem_req.addr = {attr_sel[3], sum};
      end
      S_FIN: begin
        mem_req.en = 1'b0;
      end
      default: mem_req = '0;
    endcase
  end

  always_comb begin
    sh      = '0;
    row_dec = '0;
    for (int i = 0; i < 8; i++) begin
      sh               = attr_r[5] ? 3'(i) : 3'(7 - i);
      row_dec[2*i]     = plane0_r[sh];
      row_dec[2*i + 1] = mem_rdata[sh];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // fin loads the output register itself
      if (out_valid_r && out_ready && state_r != S_FIN) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid && in_mode == bgwf_pkg::MODE_FETCH) begin
            map_addr_r <= sum;
            y_lo_r     <= in_pixel_y[2:0];
            state_r    <= color_mode ? S_ATTR : S_PL0;
          end
        end
        S_ATTR: begin
          tile_r  <= mem_rdata;
          state_r <= S_PL0;
        end
        S_PL0: begin
          tile_r  <= tile_sel;
          attr_r  <= attr_sel;
          state_r <= S_PL1;
        end
        S_PL1: begin
          plane0_r <= mem_rdata;
          state_r  <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r     <= 1'b1;
            out_pixel_row_r <= row_dec;
            out_attribute_r <= attr_r;
            state_r         <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_pixel_row = out_pixel_row_r;
  assign out_attribute = out_attribute_r;

  `BGWF_NEVER(a_no_write_busy, !in_ready && mem_req.we, "vram write while fetch busy")
  `BGWF_NEVER(a_fin_no_access, state_r == S_FIN && mem_req.en, "vram access would clobber plane 1")
  `BGWF_ASSERT(a_fin_hold, state_r == S_FIN && out_valid_r && !out_ready |=> state_r == S_FIN, "left fin with output full")
  `BGWF_ASSERT(a_out_from_fin, $rose(out_valid_r) |-> $past(state_r) == S_FIN, "result beat not from fin")

endmodule

`default_nettype wire
